// ----- hdl/adtshp_pkg.sv -----
// Shared types, constants and header decode functions for the ADTS header parser.
package adtshp_pkg;

  localparam int unsigned HDR_LEN = 7;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] frame_number;
    logic        mpeg_version;
    logic [1:0]  layer_bits;
    logic        crc_absent;
    logic [1:0]  profile_code;
    logic [3:0]  rate_index;
    logic [16:0] rate_hz;
    logic [2:0]  channel_setup;
    logic [12:0] frame_bytes;
    logic [10:0] fullness;
    logic [1:0]  extra_blocks;
  } result_t;

  // Sample rate for the frequency index; reserved and escape codes give zero.
  function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
    logic [16:0] hz;
    case (idx)
      4'd0:    hz = 17'd96000;
      4'd1:    hz = 17'd88200;
      4'd2:    hz = 17'd64000;
      4'd3:    hz = 17'd48000;
      4'd4:    hz = 17'd44100;
      4'd5:    hz = 17'd32000;
      4'd6:    hz = 17'd24000;
      4'd7:    hz = 17'd22050;
      4'd8:    hz = 17'd16000;
      4'd9:    hz = 17'd12000;
      4'd10:   hz = 17'd11025;
      4'd11:   hz = 17'd8000;
      4'd12:   hz = 17'd7350;
      default: hz = 17'd0;
    endcase
    return hz;
  endfunction

  // Thirteen-bit frame length from header bytes 3..5.
  function automatic logic [12:0] frame_len(input logic [7:0] h3, input logic [7:0] h4,
                                            input logic [7:0] h5);
    return {h3[1:0], h4, h5[7:5]};
  endfunction

  function automatic result_t decode(input logic [7:0]  h1, input logic [7:0] h2,
                                     input logic [7:0]  h3, input logic [7:0] h4,
                                     input logic [7:0]  h5, input logic [7:0] h6,
                                     input logic [15:0] num);
    result_t r;
    r.frame_number  = num;
    r.mpeg_version  = h1[3];
    r.layer_bits    = h1[2:1];
    r.crc_absent    = h1[0];
    r.profile_code  = h2[7:6];
    r.rate_index    = h2[5:2];
    r.rate_hz       = rate_lookup(h2[5:2]);
    r.channel_setup = {h2[0], h3[7:6]};
    r.frame_bytes   = frame_len(h3, h4, h5);
    r.fullness      = {h5[4:0], h6[7:2]};
    r.extra_blocks  = h6[1:0];
    return r;
  endfunction

endpackage

// ----- hdl/adtshp_core.sv -----
// Sync hunt, header capture and frame countdown for the ADTS header parser.
module adtshp_core import adtshp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output logic       emit,
  output result_t    result
);

  phase_t                phase_r, phase_nxt;
  logic                  saw_ff_r, saw_ff_nxt;
  logic [2:0]            hidx_r, hidx_nxt;
  logic [12:0]           left_r, left_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [7:0]            hdr_r [1:6];
  logic                  hdr_we;
  logic [2:0]            hdr_wa;
  logic [12:0]           len;
  logic [12:0]           left_dec;
  logic [7:0]            h6;
  logic [31:0]           cnt_wide;

  assign len      = frame_len(hdr_r[3], hdr_r[4], hdr_r[5]);
  assign left_dec = (left_r != 13'd0) ? left_r - 13'd1 : left_r;
  assign h6       = (phase_r == PH_HEAD) ? byte_in : hdr_r[6];
  assign cnt_wide = 32'(cnt_r);
  assign result   = decode(hdr_r[1], hdr_r[2], hdr_r[3], hdr_r[4], hdr_r[5], h6,
                           cnt_wide[15:0]);

  always_comb begin
    phase_nxt  = phase_r;
    saw_ff_nxt = saw_ff_r;
    hidx_nxt   = hidx_r;
    left_nxt   = left_r;
    cnt_nxt    = cnt_r;
    hdr_we     = 1'b0;
    hdr_wa     = hidx_r;
    emit       = 1'b0;
    if (step) begin
      case (phase_r)
        PH_HEAD: begin
          hdr_we = 1'b1;
          if (hidx_r == 3'(HDR_LEN - 1)) begin
            hidx_nxt   = 3'd0;
            saw_ff_nxt = 1'b0;
            if (len < 13'(HDR_LEN)) begin
              phase_nxt = PH_HUNT;
            end else if (len == 13'(HDR_LEN)) begin
              phase_nxt = PH_HUNT;
              emit      = 1'b1;
            end else begin
              left_nxt  = len - 13'(HDR_LEN);
              phase_nxt = PH_BODY;
            end
          end else begin
            hidx_nxt = hidx_r + 3'd1;
          end
        end
        PH_BODY: begin
          left_nxt = left_dec;
          if (left_dec == 13'd0) begin
            phase_nxt  = PH_HUNT;
            saw_ff_nxt = 1'b0;
            emit       = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (saw_ff_r && byte_in[7:4] == 4'hF) begin
            hdr_we     = 1'b1;
            hdr_wa     = 3'd1;
            hidx_nxt   = 3'd2;
            saw_ff_nxt = 1'b0;
            phase_nxt  = PH_HEAD;
          end else begin
            saw_ff_nxt = (byte_in == 8'hFF);
          end
        end
      endcase
      if (emit) cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      saw_ff_r <= 1'b0;
      hidx_r   <= 3'd0;
      left_r   <= 13'd0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      saw_ff_r <= saw_ff_nxt;
      hidx_r   <= hidx_nxt;
      left_r   <= left_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_r[hdr_wa] <= byte_in;
  end

endmodule

// ----- hdl/adts_frame_header_parser_top.sv -----
// Top level of the ADTS frame header parser: input register, parser core, result register.
// A word accepted into the input register is parsed once the result slot is free or draining;
// its result, if any, is loaded into the result register as it is parsed.
// Throughput: one word per cycle while the result slot is free or draining.
// Reset: synchronous, active low; hunting for sync, counters cleared, no result held.
// The header byte store is not reset; only bytes written in the current frame are read.
module adts_frame_header_parser_top import adtshp_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_frame_number,
  output logic        out_mpeg_version,
  output logic [1:0]  out_layer_bits,
  output logic        out_crc_absent,
  output logic [1:0]  out_profile_code,
  output logic [3:0]  out_rate_index,
  output logic [16:0] out_rate_hz,
  output logic [2:0]  out_channel_setup,
  output logic [12:0] out_frame_bytes,
  output logic [10:0] out_fullness,
  output logic [1:0]  out_extra_blocks
);

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       out_vld_r;
  result_t    res_r;
  result_t    res;
  logic       go;
  logic       emit;

  // Advance the held word into the parser whenever the result slot is free or draining.
  assign go       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || go;

  // Input register: take a new word when empty or while the held word is being parsed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_stream_byte;
  end

  adtshp_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (go),
    .byte_in(byte_r),
    .emit   (emit),
    .result (res)
  );

  // Result register: load on a frame's last word, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) res_r <= res;
  end

  assign out_valid         = out_vld_r;
  assign out_frame_number  = res_r.frame_number;
  assign out_mpeg_version  = res_r.mpeg_version;
  assign out_layer_bits    = res_r.layer_bits;
  assign out_crc_absent    = res_r.crc_absent;
  assign out_profile_code  = res_r.profile_code;
  assign out_rate_index    = res_r.rate_index;
  assign out_rate_hz       = res_r.rate_hz;
  assign out_channel_setup = res_r.channel_setup;
  assign out_frame_bytes   = res_r.frame_bytes;
  assign out_fullness      = res_r.fullness;
  assign out_extra_blocks  = res_r.extra_blocks;

  // A reported frame is never shorter than its header.
  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.frame_bytes >= 13'(HDR_LEN))
    else $error("result frame length below header length");

  // Rate is zero exactly for reserved and escape indexes.
  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((res_r.rate_index >= 4'd13) == (res_r.rate_hz == 17'd0)))
    else $error("rate and rate index disagree");

  // A held word that was not parsed stays held, unchanged.
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !go) |=> (in_vld_r && $stable(byte_r)))
    else $error("unparsed input word lost or changed");

  // A waiting result is not overwritten.
  a_hold_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(res_r)))
    else $error("waiting result overwritten");

endmodule
